>>> src/ilfm_pkg.sv
// ----------------------------------------------------------------------------
// ilfm_pkg
// Shared types, constants and helpers for the interlock loop fault monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ilfm_pkg;

    localparam int unsigned POINT_COUNT = 9;

    typedef logic [POINT_COUNT-1:0] points_t;
    typedef logic [3:0]             phase_t;
    typedef logic [3:0]             level_t;
    typedef logic [2:0]             event_t;

    localparam phase_t PHASE_WAIT_READY = 4'd9;
    localparam phase_t PHASE_MONITOR    = 4'd10;

    localparam level_t LEVEL_NONE = 4'd15;

    localparam int unsigned POINT_HVD  = 3;
    localparam int unsigned POINT_CBRB = 6;
    localparam int unsigned POINT_TSMS = 7;
    localparam int unsigned POINT_HW   = 8;

    localparam event_t EV_NONE     = 3'd0;
    localparam event_t EV_FAULT    = 3'd1;
    localparam event_t EV_READY    = 3'd2;
    localparam event_t EV_PRESSED  = 3'd3;
    localparam event_t EV_RELEASED = 3'd4;

    // index of the lowest open point, point count when all are closed
    function automatic logic [3:0] first_open(input points_t pts);
        logic [3:0] idx;
        idx = 4'(POINT_COUNT);
        for (int k = POINT_COUNT - 1; k >= 0; k--)
        begin
            if (!pts[k])
            begin
                idx = 4'(k);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> src/interlock_loop_fault_monitor.sv
// ----------------------------------------------------------------------------
// interlock_loop_fault_monitor
// Startup sequencing and HV fault reporting over nine interlock sense points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one monitoring tick: the nine
//   sense bits and the system-up ready flag. Output channel (out_valid /
//   out_stall) carries one result per tick: event code, first open point,
//   initialised flag and the contactor-close pulse.
//   The configuration channel (cfg_valid / cfg_ready) writes the skip bit; it
//   is always ready and should only be written while the block is idle.
//   The result is valid in the cycle after the transfer in. Throughput is one
//   tick per cycle while the receiver does not stall, set by the result
//   register stage that follows the combinational tick logic.
//   Reset puts startup back to waiting for the first point, clears the
//   reported level, button mark, initialised flag and skip bit, and empties
//   the result register.
//   While the receiver stalls a held result, in_stall is raised and no new
//   tick is taken; the held result stays unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module interlock_loop_fault_monitor
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              skip_charging_checks,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ilfm_pkg::points_t sense_bits,
    input  wire logic              system_up_ready,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output ilfm_pkg::event_t       event_code,
    output logic [3:0]             first_failed_point,
    output logic                   monitor_initialized,
    output logic                   close_ams_contactor
);

    import ilfm_pkg::*;

    logic    skip_reg;
    phase_t  phase_reg,     phase_next;
    level_t  level_reg,     level_next;
    logic    pressed_reg,   pressed_next;
    logic    init_reg,      init_next;

    logic       out_valid_reg;
    event_t     event_reg,   event_next;
    logic [3:0] first_reg,   first_next;
    logic       pulse_reg,   pulse_next;

    logic    accept;
    points_t pts;
    points_t masked;
    phase_t  chained;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    always_comb
    begin
        pts = sense_bits;
        if (skip_reg)
        begin
            pts[POINT_CBRB] = 1'b1;
            pts[POINT_TSMS] = 1'b1;
        end
    end

    // points below the current phase count as passed
    always_comb
    begin
        masked = pts;
        for (int k = 0; k < POINT_COUNT; k++)
        begin
            if (4'(k) < phase_reg)
            begin
                masked[k] = 1'b1;
            end
        end
        chained = first_open(masked);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        level_next   = level_reg;
        pressed_next = pressed_reg;
        init_next    = init_reg;
        event_next   = EV_NONE;
        pulse_next   = 1'b0;
        first_next   = first_open(pts);

        if (phase_reg < PHASE_WAIT_READY)
        begin
            phase_next = chained;
            if (phase_reg <= 4'(POINT_HVD) && chained > 4'(POINT_HVD))
            begin
                pulse_next = 1'b1;
            end
            if (chained == PHASE_WAIT_READY && system_up_ready)
            begin
                event_next = EV_READY;
                init_next  = 1'b1;
                phase_next = PHASE_MONITOR;
            end
        end
        else if (phase_reg == PHASE_WAIT_READY)
        begin
            if (system_up_ready)
            begin
                event_next = EV_READY;
                init_next  = 1'b1;
                phase_next = PHASE_MONITOR;
            end
        end
        else
        begin
            if (!pts[0] && level_reg > 4'd0)
            begin
                event_next = EV_FAULT;
                level_next = 4'd0;
            end
            else if (!pts[1] && level_reg > 4'd1)
            begin
                event_next = EV_FAULT;
                level_next = 4'd1;
            end
            else if (!pts[2] && level_reg > 4'd2)
            begin
                event_next = EV_FAULT;
                level_next = 4'd2;
            end
            else if (!pts[POINT_HVD] && level_reg > 4'(POINT_HVD))
            begin
                event_next = EV_FAULT;
                level_next = 4'(POINT_HVD);
            end
            else if (!pts[POINT_CBRB] && level_reg > 4'(POINT_CBRB))
            begin
                if (!pressed_reg)
                begin
                    event_next = EV_PRESSED;
                    level_next = 4'(POINT_CBRB);
                end
                pressed_next = 1'b1;
            end
            else if (pts[POINT_CBRB] && pressed_reg)
            begin
                event_next   = EV_RELEASED;
                pressed_next = 1'b0;
                level_next   = LEVEL_NONE;
            end
            else if (!pts[POINT_TSMS] && level_reg > 4'(POINT_TSMS))
            begin
                event_next = EV_FAULT;
                level_next = 4'(POINT_TSMS);
            end
            else if (!pts[POINT_HW] && level_reg > 4'(POINT_HW))
            begin
                event_next = EV_FAULT;
                level_next = 4'(POINT_HW);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= 1'b0;
            phase_reg     <= '0;
            level_reg     <= LEVEL_NONE;
            pressed_reg   <= 1'b0;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                skip_reg <= skip_charging_checks;
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                level_reg   <= level_next;
                pressed_reg <= pressed_next;
                init_reg    <= init_next;
            end
            out_valid_reg <= accept | (out_valid_reg & out_stall);
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg <= event_next;
            first_reg <= first_next;
            pulse_reg <= pulse_next;
        end
    end

    logic init_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_out_reg <= 1'b0;
        end
        else if (accept)
        begin
            init_out_reg <= init_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign event_code          = event_reg;
    assign first_failed_point  = first_reg;
    assign monitor_initialized = init_out_reg;
    assign close_ams_contactor = pulse_reg;

`ifndef SYNTH
    a_ready_sets_init : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_code == EV_READY) |-> monitor_initialized)
        else $error("ready event without initialised flag");

    a_init_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |=> init_reg)
        else $error("initialised flag dropped");

    a_level_legal : assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg <= 4'd3 || level_reg == 4'd6 || level_reg == 4'd7 ||
         level_reg == 4'd8 || level_reg == LEVEL_NONE))
        else $error("reported level holds an unreachable value");

    a_pulse_in_startup : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pulse_next) |-> (phase_reg < PHASE_WAIT_READY))
        else $error("contactor pulse outside startup");
`endif

endmodule

`default_nettype wire
